FILE: design/rv64d_pkg.sv
// rv64d_pkg: shared types, opcode constants and control bundle for the
// rv64 instruction decoder pipeline. No dependencies.
`default_nettype none

package rv64d_pkg;

  localparam int unsigned INSTR_W = 32;
  localparam int unsigned XLEN    = 64;
  localparam int unsigned REG_W   = 5;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMMW = 7'h1B;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_OPW    = 7'h3B;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULD = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_BASE = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_MUL = 4'd1,
    ALU_SUB = 4'd2,
    ALU_DIV = 4'd3,
    ALU_SLL = 4'd4,
    ALU_SRL = 4'd5,
    ALU_AND = 4'd6,
    ALU_OR  = 4'd7,
    ALU_XOR = 4'd8,
    ALU_REM = 4'd9,
    ALU_SLT = 4'd10,
    ALU_SRA = 4'd11
  } alu_op_t;

  typedef enum logic [2:0] {
    SRC_RS1_RS2 = 3'd0,
    SRC_RS1_IMM = 3'd1,
    SRC_PC_4    = 3'd2,
    SRC_PC_IMM  = 3'd3,
    SRC_IMM_0   = 3'd4
  } src_t;

  typedef enum logic [2:0] {
    BR_NONE = 3'd0,
    BR_JALR = 3'd1,
    BR_BEQ  = 3'd2,
    BR_BNE  = 3'd3,
    BR_BLT  = 3'd4,
    BR_BGE  = 3'd5,
    BR_JAL  = 3'd6
  } br_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_t;

  typedef enum logic [2:0] {
    IMM_NONE = 3'd0,
    IMM_I    = 3'd1,
    IMM_SH   = 3'd2,
    IMM_S    = 3'd3,
    IMM_B    = 3'd4,
    IMM_U    = 3'd5,
    IMM_J    = 3'd6
  } imm_sel_t;

  typedef struct packed {
    alu_op_t    alu;
    src_t       src;
    logic       wm;
    br_t        br;
    mem_t       mk;
    logic [3:0] ms;
    logic       rw;
    logic       lr;
    imm_sel_t   imm_sel;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    alu: ALU_ADD, src: SRC_RS1_RS2, wm: 1'b0, br: BR_NONE, mk: MEM_NONE,
    ms: 4'd0, rw: 1'b0, lr: 1'b0, imm_sel: IMM_NONE
  };

endpackage

`default_nettype wire

FILE: design/rv64_instruction_decoder.sv
// rv64_instruction_decoder: top level, three-stage RV64IM decode pipeline.
// Depends on rv64d_pkg and rv64d_classify.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | start / busy     | in_instruction
//   result   | out_valid strobe | out_alu_operation .. out_immediate
//
// The result passes these registers in order from acceptance to out_valid:
// capture register, opcode/funct classify register, immediate/output register.
// One beat is accepted every cycle; busy is always low.
// Results are strobed for one cycle; the receiver cannot stall the pipe.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none

module rv64_instruction_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rv64d_pkg::INSTR_W-1:0] in_instruction,
  output logic                               out_valid,
  output logic [3:0]                         out_alu_operation,
  output logic [2:0]                         out_operand_source,
  output logic                               out_word_mode,
  output logic [2:0]                         out_branch_kind,
  output logic [1:0]                         out_memory_kind,
  output logic [3:0]                         out_memory_size,
  output logic                               out_register_write,
  output logic                               out_load_to_register,
  output logic [rv64d_pkg::REG_W-1:0]        out_destination_register,
  output logic [rv64d_pkg::REG_W-1:0]        out_source_register_one,
  output logic [rv64d_pkg::REG_W-1:0]        out_source_register_two,
  output logic signed [rv64d_pkg::XLEN-1:0]  out_immediate
);

  logic                          s1_valid_r;
  logic [rv64d_pkg::INSTR_W-1:0] s1_word_r;
  logic                          s2_valid;
  logic [rv64d_pkg::INSTR_W-1:0] s2_word;
  rv64d_pkg::ctrl_t              s2_ctrl;
  logic [rv64d_pkg::XLEN-1:0]    imm_nxt;
  logic                          out_valid_r;
  rv64d_pkg::ctrl_t              out_ctrl_r;
  logic [rv64d_pkg::INSTR_W-1:0] out_word_r;
  logic [rv64d_pkg::XLEN-1:0]    out_imm_r;

  assign busy = 1'b0;

  // capture stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_word_r <= in_instruction;
  end

  rv64d_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (s1_valid_r),
    .word_in  (s1_word_r),
    .valid_r  (s2_valid),
    .word_r   (s2_word),
    .ctrl_r   (s2_ctrl)
  );

  // immediate assembly
  always_comb begin
    unique case (s2_ctrl.imm_sel)
      rv64d_pkg::IMM_I:  imm_nxt = {{52{s2_word[31]}}, s2_word[31:20]};
      rv64d_pkg::IMM_SH: imm_nxt = {58'd0, s2_word[25:20]};
      rv64d_pkg::IMM_S:  imm_nxt = {{52{s2_word[31]}}, s2_word[31:25], s2_word[11:7]};
      rv64d_pkg::IMM_B:  imm_nxt = {{51{s2_word[31]}}, s2_word[31], s2_word[7],
                                    s2_word[30:25], s2_word[11:8], 1'b0};
      rv64d_pkg::IMM_U:  imm_nxt = {{32{s2_word[31]}}, s2_word[31:12], 12'd0};
      rv64d_pkg::IMM_J:  imm_nxt = {{43{s2_word[31]}}, s2_word[31], s2_word[19:12],
                                    s2_word[20], s2_word[30:21], 1'b0};
      default:           imm_nxt = '0;
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctrl_r <= s2_ctrl;
    out_word_r <= s2_word;
    out_imm_r  <= imm_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_alu_operation        = out_ctrl_r.alu;
  assign out_operand_source       = out_ctrl_r.src;
  assign out_word_mode            = out_ctrl_r.wm;
  assign out_branch_kind          = out_ctrl_r.br;
  assign out_memory_kind          = out_ctrl_r.mk;
  assign out_memory_size          = out_ctrl_r.ms;
  assign out_register_write       = out_ctrl_r.rw;
  assign out_load_to_register     = out_ctrl_r.lr;
  assign out_destination_register = out_word_r[11:7];
  assign out_source_register_one  = out_word_r[19:15];
  assign out_source_register_two  = out_word_r[24:20];
  assign out_immediate            = out_imm_r;

`ifndef SYNTHESIS
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result beat without an accepted beat three cycles earlier");

  a_rd_follows_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_destination_register == $past(in_instruction[11:7], 3))
    else $error("destination register does not match accepted word");

  a_load_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_memory_kind == rv64d_pkg::MEM_LOAD
      |-> out_register_write && out_load_to_register)
    else $error("load without write-back from memory");

  a_mem_has_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_memory_kind != rv64d_pkg::MEM_NONE |-> out_memory_size != 4'd0)
    else $error("memory access with zero size");

  a_nop_zero_imm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_register_write && out_memory_kind == rv64d_pkg::MEM_NONE
      && out_branch_kind == rv64d_pkg::BR_NONE |-> out_immediate == '0)
    else $error("rejected encoding carries a nonzero immediate");
`endif

endmodule

`default_nettype wire

FILE: design/rv64d_classify.sv
// rv64d_classify: second pipeline stage, opcode/funct decode into a
// registered control bundle. Depends on rv64d_pkg.
`default_nettype none

module rv64d_classify (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_in,
  input  wire logic [rv64d_pkg::INSTR_W-1:0] word_in,
  output logic                               valid_r,
  output logic [rv64d_pkg::INSTR_W-1:0]      word_r,
  output rv64d_pkg::ctrl_t                   ctrl_r
);

  rv64d_pkg::ctrl_t ctrl_nxt;
  logic [6:0]       opc;
  logic [2:0]       f3;
  logic [6:0]       f7;
  logic [5:0]       f6;
  logic             wide;
  logic             ok;

  assign opc  = word_in[6:0];
  assign f3   = word_in[14:12];
  assign f7   = word_in[31:25];
  assign f6   = word_in[31:26];
  assign wide = (opc == rv64d_pkg::OPC_OPW) || (opc == rv64d_pkg::OPC_OPIMMW);

  always_comb begin
    ctrl_nxt = rv64d_pkg::CTRL_NOP;
    ok       = 1'b1;
    unique case (opc)
      rv64d_pkg::OPC_OP, rv64d_pkg::OPC_OPW: begin
        ctrl_nxt.src = rv64d_pkg::SRC_RS1_RS2;
        ctrl_nxt.wm  = wide;
        ctrl_nxt.rw  = 1'b1;
        ok           = 1'b0;
        unique case (f3)
          3'd0: begin
            if (f7 == rv64d_pkg::F7_BASE) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_ADD; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_MULD) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_MUL; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_ALT) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SUB; ok = 1'b1;
            end
          end
          3'd1: begin
            if (f7 == rv64d_pkg::F7_BASE) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SLL; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_MULD && !wide) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_MUL; ok = 1'b1;
            end
          end
          3'd2: begin
            if (f7 == rv64d_pkg::F7_BASE && !wide) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SLT; ok = 1'b1;
            end
          end
          3'd4: begin
            if (f7 == rv64d_pkg::F7_BASE && !wide) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_XOR; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_MULD) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_DIV; ok = 1'b1;
            end
          end
          3'd5: begin
            if (f7 == rv64d_pkg::F7_BASE) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SRL; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_ALT) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SRA; ok = 1'b1;
            end
          end
          3'd6: begin
            if (f7 == rv64d_pkg::F7_BASE && !wide) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_OR; ok = 1'b1;
            end else if (f7 == rv64d_pkg::F7_MULD) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_REM; ok = 1'b1;
            end
          end
          3'd7: begin
            if (f7 == rv64d_pkg::F7_BASE && !wide) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_AND; ok = 1'b1;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      rv64d_pkg::OPC_LOAD: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_RS1_IMM;
        ctrl_nxt.mk      = rv64d_pkg::MEM_LOAD;
        ctrl_nxt.ms      = {1'b0, f3} + 4'd1;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.lr      = 1'b1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_I;
      end
      rv64d_pkg::OPC_OPIMM, rv64d_pkg::OPC_OPIMMW: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_RS1_IMM;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.wm      = wide;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_I;
        unique case (f3)
          3'd0: ctrl_nxt.alu = rv64d_pkg::ALU_ADD;
          3'd1: begin
            ctrl_nxt.alu     = rv64d_pkg::ALU_SLL;
            ctrl_nxt.imm_sel = rv64d_pkg::IMM_SH;
            ok = wide ? (f7 == rv64d_pkg::F7_BASE) : (f6 == rv64d_pkg::F6_BASE);
          end
          3'd5: begin
            ctrl_nxt.imm_sel = rv64d_pkg::IMM_SH;
            if (wide ? (f7 == rv64d_pkg::F7_BASE) : (f6 == rv64d_pkg::F6_BASE)) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SRL;
            end else if (wide ? (f7 == rv64d_pkg::F7_ALT) : (f6 == rv64d_pkg::F6_ALT)) begin
              ctrl_nxt.alu = rv64d_pkg::ALU_SRA;
            end else begin
              ok = 1'b0;
            end
          end
          3'd2: begin
            ctrl_nxt.alu = rv64d_pkg::ALU_SLT;
            ok = !wide;
          end
          3'd4: begin
            ctrl_nxt.alu = rv64d_pkg::ALU_XOR;
            ok = !wide;
          end
          3'd6: begin
            ctrl_nxt.alu = rv64d_pkg::ALU_OR;
            ok = !wide;
          end
          3'd7: begin
            ctrl_nxt.alu = rv64d_pkg::ALU_AND;
            ok = !wide;
          end
          default: ok = 1'b0;
        endcase
      end
      rv64d_pkg::OPC_JALR: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_PC_4;
        ctrl_nxt.br      = rv64d_pkg::BR_JALR;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_I;
        ok = (f3 == 3'd0);
      end
      rv64d_pkg::OPC_STORE: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_RS1_IMM;
        ctrl_nxt.mk      = rv64d_pkg::MEM_STORE;
        ctrl_nxt.ms      = {1'b0, f3} + 4'd1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_S;
      end
      rv64d_pkg::OPC_BRANCH: begin
        ctrl_nxt.alu     = rv64d_pkg::ALU_SUB;
        ctrl_nxt.src     = rv64d_pkg::SRC_RS1_RS2;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_B;
        unique case (f3)
          3'd0:    ctrl_nxt.br = rv64d_pkg::BR_BEQ;
          3'd1:    ctrl_nxt.br = rv64d_pkg::BR_BNE;
          3'd4:    ctrl_nxt.br = rv64d_pkg::BR_BLT;
          3'd5:    ctrl_nxt.br = rv64d_pkg::BR_BGE;
          default: ok = 1'b0;
        endcase
      end
      rv64d_pkg::OPC_AUIPC: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_PC_IMM;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_U;
      end
      rv64d_pkg::OPC_LUI: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_IMM_0;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_U;
      end
      rv64d_pkg::OPC_JAL: begin
        ctrl_nxt.src     = rv64d_pkg::SRC_PC_4;
        ctrl_nxt.br      = rv64d_pkg::BR_JAL;
        ctrl_nxt.rw      = 1'b1;
        ctrl_nxt.imm_sel = rv64d_pkg::IMM_J;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      ctrl_nxt = rv64d_pkg::CTRL_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_in;
    ctrl_r <= ctrl_nxt;
  end

endmodule

`default_nettype wire

FILE: dv/rv64_instruction_decoder_tb.sv
// rv64_instruction_decoder_tb: drives instruction words into the decoder and
// checks every decoded bundle against an in-bench decode of the same word.
// Depends on rv64d_pkg and the rv64_instruction_decoder design.
`default_nettype none

module rv64_instruction_decoder_tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned SETTLE_CYCLES    = 8;

  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] F7_SRAI_HI = {rv64d_pkg::F6_ALT, 1'b1};

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;

  typedef struct packed {
    rv64d_pkg::alu_op_t alu;
    rv64d_pkg::src_t    src;
    logic               wm;
    rv64d_pkg::br_t     br;
    rv64d_pkg::mem_t    mk;
    logic [3:0]         ms;
    logic               rw;
    logic               lr;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic [63:0]        imm;
  } decoded_t;

  class decode_scoreboard;
    localparam int unsigned PRINT_CAP = 100;
    decoded_t    pending_decodes[$];
    logic [31:0] pending_words[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function decoded_t decode_word(logic [31:0] w);
      decoded_t    d;
      logic [6:0]  opc;
      logic [6:0]  f7;
      logic [5:0]  f6;
      logic [2:0]  f3;
      logic [63:0] i12;
      logic [63:0] sh;
      logic        wide;
      logic        ok;
      opc  = w[6:0];
      f3   = w[14:12];
      f7   = w[31:25];
      f6   = w[31:26];
      i12  = {{52{w[31]}}, w[31:20]};
      sh   = {58'd0, w[25:20]};
      wide = (opc == rv64d_pkg::OPC_OPW) || (opc == rv64d_pkg::OPC_OPIMMW);
      ok   = 1'b1;
      d    = '0;
      case (opc)
        rv64d_pkg::OPC_OP, rv64d_pkg::OPC_OPW: begin
          d.src = rv64d_pkg::SRC_RS1_RS2;
          d.wm  = wide;
          d.rw  = 1'b1;
          case (f3)
            F3_ADD: begin
              if (f7 == rv64d_pkg::F7_BASE) d.alu = rv64d_pkg::ALU_ADD;
              else if (f7 == rv64d_pkg::F7_MULD) d.alu = rv64d_pkg::ALU_MUL;
              else if (f7 == rv64d_pkg::F7_ALT) d.alu = rv64d_pkg::ALU_SUB;
              else ok = 1'b0;
            end
            F3_SLL: begin
              if (f7 == rv64d_pkg::F7_BASE) d.alu = rv64d_pkg::ALU_SLL;
              else if (f7 == rv64d_pkg::F7_MULD && !wide) d.alu = rv64d_pkg::ALU_MUL;
              else ok = 1'b0;
            end
            F3_SLT: begin
              if (f7 == rv64d_pkg::F7_BASE && !wide) d.alu = rv64d_pkg::ALU_SLT;
              else ok = 1'b0;
            end
            F3_XOR: begin
              if (f7 == rv64d_pkg::F7_BASE && !wide) d.alu = rv64d_pkg::ALU_XOR;
              else if (f7 == rv64d_pkg::F7_MULD) d.alu = rv64d_pkg::ALU_DIV;
              else ok = 1'b0;
            end
            F3_SR: begin
              if (f7 == rv64d_pkg::F7_BASE) d.alu = rv64d_pkg::ALU_SRL;
              else if (f7 == rv64d_pkg::F7_ALT) d.alu = rv64d_pkg::ALU_SRA;
              else ok = 1'b0;
            end
            F3_OR: begin
              if (f7 == rv64d_pkg::F7_BASE && !wide) d.alu = rv64d_pkg::ALU_OR;
              else if (f7 == rv64d_pkg::F7_MULD) d.alu = rv64d_pkg::ALU_REM;
              else ok = 1'b0;
            end
            F3_AND: begin
              if (f7 == rv64d_pkg::F7_BASE && !wide) d.alu = rv64d_pkg::ALU_AND;
              else ok = 1'b0;
            end
            default: ok = 1'b0;
          endcase
        end
        rv64d_pkg::OPC_LOAD: begin
          d.src = rv64d_pkg::SRC_RS1_IMM;
          d.mk  = rv64d_pkg::MEM_LOAD;
          d.ms  = {1'b0, f3} + 4'd1;
          d.rw  = 1'b1;
          d.lr  = 1'b1;
          d.imm = i12;
        end
        rv64d_pkg::OPC_OPIMM, rv64d_pkg::OPC_OPIMMW: begin
          d.src = rv64d_pkg::SRC_RS1_IMM;
          d.rw  = 1'b1;
          d.wm  = wide;
          d.imm = i12;
          case (f3)
            F3_ADD: d.alu = rv64d_pkg::ALU_ADD;
            F3_SLL: begin
              if ((!wide && f6 != rv64d_pkg::F6_BASE) || (wide && f7 != rv64d_pkg::F7_BASE))
                ok = 1'b0;
              d.alu = rv64d_pkg::ALU_SLL;
              d.imm = sh;
            end
            F3_SR: begin
              if (!wide && f6 == rv64d_pkg::F6_BASE) d.alu = rv64d_pkg::ALU_SRL;
              else if (!wide && f6 == rv64d_pkg::F6_ALT) d.alu = rv64d_pkg::ALU_SRA;
              else if (wide && f7 == rv64d_pkg::F7_BASE) d.alu = rv64d_pkg::ALU_SRL;
              else if (wide && f7 == rv64d_pkg::F7_ALT) d.alu = rv64d_pkg::ALU_SRA;
              else ok = 1'b0;
              d.imm = sh;
            end
            F3_SLT: begin
              d.alu = rv64d_pkg::ALU_SLT;
              ok    = !wide;
            end
            F3_XOR: begin
              d.alu = rv64d_pkg::ALU_XOR;
              ok    = !wide;
            end
            F3_OR: begin
              d.alu = rv64d_pkg::ALU_OR;
              ok    = !wide;
            end
            F3_AND: begin
              d.alu = rv64d_pkg::ALU_AND;
              ok    = !wide;
            end
            default: ok = 1'b0;
          endcase
        end
        rv64d_pkg::OPC_JALR: begin
          ok    = (f3 == F3_ADD);
          d.src = rv64d_pkg::SRC_PC_4;
          d.br  = rv64d_pkg::BR_JALR;
          d.rw  = 1'b1;
          d.imm = i12;
        end
        rv64d_pkg::OPC_STORE: begin
          d.src = rv64d_pkg::SRC_RS1_IMM;
          d.mk  = rv64d_pkg::MEM_STORE;
          d.ms  = {1'b0, f3} + 4'd1;
          d.imm = {{52{w[31]}}, w[31:25], w[11:7]};
        end
        rv64d_pkg::OPC_BRANCH: begin
          case (f3)
            F3_BEQ: d.br = rv64d_pkg::BR_BEQ;
            F3_BNE: d.br = rv64d_pkg::BR_BNE;
            F3_BLT: d.br = rv64d_pkg::BR_BLT;
            F3_BGE: d.br = rv64d_pkg::BR_BGE;
            default: ok = 1'b0;
          endcase
          d.alu = rv64d_pkg::ALU_SUB;
          d.src = rv64d_pkg::SRC_RS1_RS2;
          d.imm = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        rv64d_pkg::OPC_AUIPC: begin
          d.src = rv64d_pkg::SRC_PC_IMM;
          d.rw  = 1'b1;
          d.imm = {{32{w[31]}}, w[31:12], 12'd0};
        end
        rv64d_pkg::OPC_LUI: begin
          d.src = rv64d_pkg::SRC_IMM_0;
          d.rw  = 1'b1;
          d.imm = {{32{w[31]}}, w[31:12], 12'd0};
        end
        rv64d_pkg::OPC_JAL: begin
          d.src = rv64d_pkg::SRC_PC_4;
          d.br  = rv64d_pkg::BR_JAL;
          d.rw  = 1'b1;
          d.imm = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        default: ok = 1'b0;
      endcase
      if (!ok) d = '0;
      d.rd  = w[11:7];
      d.rs1 = w[19:15];
      d.rs2 = w[24:20];
      return d;
    endfunction

    function void note_beat(logic [31:0] w);
      pending_decodes.push_back(decode_word(w));
      pending_words.push_back(w);
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("ERROR: %s", msg);
    endtask

    function string field_msg(string name, logic [31:0] w, logic [63:0] got, logic [63:0] want);
      return $sformatf("%s for word %h: got %0h, want %0h", name, w, got, want);
    endfunction

    task check_beat(decoded_t got);
      decoded_t    want;
      logic [31:0] w;
      if (pending_decodes.size() == 0) begin
        report($sformatf("result beat with nothing pending, rd %0d", got.rd));
        return;
      end
      want = pending_decodes.pop_front();
      w    = pending_words.pop_front();
      if (got.alu !== want.alu)
        report(field_msg("alu_operation", w, 64'(got.alu), 64'(want.alu)));
      if (got.src !== want.src)
        report(field_msg("operand_source", w, 64'(got.src), 64'(want.src)));
      if (got.wm !== want.wm)
        report(field_msg("word_mode", w, 64'(got.wm), 64'(want.wm)));
      if (got.br !== want.br)
        report(field_msg("branch_kind", w, 64'(got.br), 64'(want.br)));
      if (got.mk !== want.mk)
        report(field_msg("memory_kind", w, 64'(got.mk), 64'(want.mk)));
      if (got.ms !== want.ms)
        report(field_msg("memory_size", w, 64'(got.ms), 64'(want.ms)));
      if (got.rw !== want.rw)
        report(field_msg("register_write", w, 64'(got.rw), 64'(want.rw)));
      if (got.lr !== want.lr)
        report(field_msg("load_to_register", w, 64'(got.lr), 64'(want.lr)));
      if (got.rd !== want.rd)
        report(field_msg("destination_register", w, 64'(got.rd), 64'(want.rd)));
      if (got.rs1 !== want.rs1)
        report(field_msg("source_register_one", w, 64'(got.rs1), 64'(want.rs1)));
      if (got.rs2 !== want.rs2)
        report(field_msg("source_register_two", w, 64'(got.rs2), 64'(want.rs2)));
      if (got.imm !== want.imm)
        report(field_msg("immediate", w, got.imm, want.imm));
    endtask

    task flush_leftovers();
      while (pending_decodes.size() != 0) begin
        void'(pending_decodes.pop_front());
        report($sformatf("no result beat for word %h", pending_words.pop_front()));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [31:0] in_instruction = '0;
  logic        busy;
  logic        out_valid;
  logic [3:0]  out_alu_operation;
  logic [2:0]  out_operand_source;
  logic        out_word_mode;
  logic [2:0]  out_branch_kind;
  logic [1:0]  out_memory_kind;
  logic [3:0]  out_memory_size;
  logic        out_register_write;
  logic        out_load_to_register;
  logic [4:0]  out_destination_register;
  logic [4:0]  out_source_register_one;
  logic [4:0]  out_source_register_two;
  logic signed [63:0] out_immediate;

  int unsigned      cycle_count = 0;
  decode_scoreboard sb = new();

  rv64_instruction_decoder DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_instruction           (in_instruction),
    .out_valid                (out_valid),
    .out_alu_operation        (out_alu_operation),
    .out_operand_source       (out_operand_source),
    .out_word_mode            (out_word_mode),
    .out_branch_kind          (out_branch_kind),
    .out_memory_kind          (out_memory_kind),
    .out_memory_size          (out_memory_size),
    .out_register_write       (out_register_write),
    .out_load_to_register     (out_load_to_register),
    .out_destination_register (out_destination_register),
    .out_source_register_one  (out_source_register_one),
    .out_source_register_two  (out_source_register_two),
    .out_immediate            (out_immediate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rv64_instruction_decoder_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    decoded_t seen;
    if (rst_n) begin
      if (start && busy === 1'b0) sb.note_beat(in_instruction);
      if (out_valid !== 1'b0) begin
        seen.alu = rv64d_pkg::alu_op_t'(out_alu_operation);
        seen.src = rv64d_pkg::src_t'(out_operand_source);
        seen.wm  = out_word_mode;
        seen.br  = rv64d_pkg::br_t'(out_branch_kind);
        seen.mk  = rv64d_pkg::mem_t'(out_memory_kind);
        seen.ms  = out_memory_size;
        seen.rw  = out_register_write;
        seen.lr  = out_load_to_register;
        seen.rd  = out_destination_register;
        seen.rs1 = out_source_register_one;
        seen.rs2 = out_source_register_two;
        seen.imm = out_immediate;
        sb.check_beat(seen);
      end
    end
  end

  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] random_word();
    logic [6:0] opc;
    logic [6:0] f7;
    opc = rv64d_pkg::OPC_OP;
    f7  = rv64d_pkg::F7_BASE;
    if ($urandom_range(99) < 12) return $urandom;
    case ($urandom_range(10))
      0: opc = rv64d_pkg::OPC_LOAD;
      1: opc = rv64d_pkg::OPC_OPIMM;
      2: opc = rv64d_pkg::OPC_AUIPC;
      3: opc = rv64d_pkg::OPC_OPIMMW;
      4: opc = rv64d_pkg::OPC_STORE;
      5: opc = rv64d_pkg::OPC_OP;
      6: opc = rv64d_pkg::OPC_LUI;
      7: opc = rv64d_pkg::OPC_OPW;
      8: opc = rv64d_pkg::OPC_BRANCH;
      9: opc = rv64d_pkg::OPC_JALR;
      default: opc = rv64d_pkg::OPC_JAL;
    endcase
    case ($urandom_range(5))
      0: f7 = rv64d_pkg::F7_BASE;
      1: f7 = rv64d_pkg::F7_MULD;
      2: f7 = rv64d_pkg::F7_ALT;
      3: f7 = F7_SRAI_HI;
      default: f7 = 7'($urandom);
    endcase
    return enc(f7, 5'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), opc);
  endfunction

  task automatic send(logic [31:0] w, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      in_instruction <= $urandom;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_instruction <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_decodes.size() != 0);
  endtask

  task automatic send_directed();
    send(32'h0000_0000, 0);
    send(32'hFFFF_FFFF, 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM), 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd31, 5'd31, F3_ADD, 5'd31, rv64d_pkg::OPC_OP), 0);
    send(enc(rv64d_pkg::F7_MULD, 5'd4, 5'd5, F3_SLL, 5'd6, rv64d_pkg::OPC_OP), 0);
    send(enc(rv64d_pkg::F7_MULD, 5'd4, 5'd5, F3_SLL, 5'd6, rv64d_pkg::OPC_OPW), 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd1, 5'd1, F3_SLTU, 5'd1, rv64d_pkg::OPC_OP), 0);
    send(enc(rv64d_pkg::F7_MULD, 5'd10, 5'd11, F3_OR, 5'd12, rv64d_pkg::OPC_OPW), 0);
    send(enc(rv64d_pkg::F7_ALT, 5'd13, 5'd14, F3_SR, 5'd15, rv64d_pkg::OPC_OPW), 0);
    send(enc(7'h7F, 5'd31, 5'd31, F3_AND, 5'd31, rv64d_pkg::OPC_LOAD), 0);
    send(enc(7'h40, 5'd0, 5'd1, F3_ADD, 5'd2, rv64d_pkg::OPC_OPIMM), 0);
    send(enc(7'h3F, 5'd31, 5'd3, F3_XOR, 5'd4, rv64d_pkg::OPC_OPIMM), 0);
    send(enc(F7_SRAI_HI, 5'd31, 5'd5, F3_SR, 5'd6, rv64d_pkg::OPC_OPIMM), 0);
    send(enc(F7_SRAI_HI, 5'd31, 5'd5, F3_SR, 5'd6, rv64d_pkg::OPC_OPIMMW), 0);
    send(enc(7'h02, 5'd0, 5'd7, F3_SLL, 5'd8, rv64d_pkg::OPC_OPIMM), 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd0, 5'd0, F3_SLT, 5'd0, rv64d_pkg::OPC_OPIMMW), 0);
    send(enc(7'h40, 5'd0, 5'd1, F3_ADD, 5'd1, rv64d_pkg::OPC_JALR), 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd0, 5'd1, F3_SLL, 5'd1, rv64d_pkg::OPC_JALR), 0);
    send(enc(7'h40, 5'd0, 5'd2, F3_ADD, 5'd0, rv64d_pkg::OPC_STORE), 0);
    send(enc(7'h3F, 5'd31, 5'd2, F3_AND, 5'd31, rv64d_pkg::OPC_STORE), 0);
    send(enc(7'h40, 5'd2, 5'd1, F3_BEQ, 5'd0, rv64d_pkg::OPC_BRANCH), 0);
    send(enc(7'h3F, 5'd2, 5'd1, F3_BGE, 5'd31, rv64d_pkg::OPC_BRANCH), 0);
    send(enc(rv64d_pkg::F7_BASE, 5'd2, 5'd1, F3_BLTU, 5'd0, rv64d_pkg::OPC_BRANCH), 0);
    send(32'hFFFF_F017, 0);
    send(32'h8000_00B7, 0);
    send(32'hFFFF_F0EF, 0);
  endtask

  initial begin
    int unsigned idle_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_directed();
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 11;
      endcase
      repeat (RANDOM_PER_PHASE) send(random_word(), idle_pct);
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();
    if (sb.mismatch_count == 0) begin
      $display("rv64_instruction_decoder_tb: done, clean");
    end else begin
      $display("rv64_instruction_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/rv64d_pkg.sv
design/rv64d_classify.sv
design/rv64_instruction_decoder.sv
dv/rv64_instruction_decoder_tb.sv
